[rtl/core/md5_pkg.sv]
// Shared types, constants and round functions for the MD5 digest block.
// Used by md5_front, md5_queue, md5_back and md5_message_digest.
// No dependencies.
package md5_pkg;

    typedef enum logic {
        F_DATA,
        F_PAD
    } t_front_st;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_ADD,
        B_OUT
    } t_back_st;

    // front -> queue: word write and block commit
    typedef struct packed {
        logic        we;
        logic [3:0]  addr;
        logic [31:0] data;
        logic        commit;
        logic        fin;
    } t_wr_req;

    // back -> queue: word read address and slot hand-back
    typedef struct packed {
        logic [3:0] addr;
        logic       done;
    } t_rd_req;

    // queue -> back: block status and registered read data
    typedef struct packed {
        logic        avail;
        logic        fin;
        logic [31:0] data;
    } t_rd_rsp;

    localparam logic [31:0] IV [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [31:0] RK [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // step on which the first round's a+K+M sum is formed from the chain
    localparam logic [6:0] STEP_FIRST_AKM = 7'd2;
    // first step that executes a round, and the step of the last round
    localparam logic [6:0] STEP_FIRST_ROUND = 7'd3;
    localparam logic [6:0] STEP_LAST_ROUND  = 7'd66;

    function automatic logic [31:0] rol(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} << n;
        return t[63:32];
    endfunction

    // message word used by round j
    function automatic logic [3:0] msg_index(input logic [5:0] j);
        logic [3:0] j4;
        logic [3:0] g;
        j4 = j[3:0];
        unique case (j[5:4])
            2'd0: g = j4;
            2'd1: g = j4 + {j4[1:0], 2'b00} + 4'd1;
            2'd2: g = j4 + {j4[2:0], 1'b0} + 4'd5;
            2'd3: g = {j4[0], 3'b000} - j4;
            default: g = j4;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] round_f(input logic [1:0] grp, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        unique case (grp)
            2'd0: f = (b & c) | (~b & d);
            2'd1: f = (d & b) | (~d & c);
            2'd2: f = b ^ c ^ d;
            2'd3: f = c ^ (b | ~d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

[rtl/core/md5_front.sv]
// Front end: takes message bytes, packs them into block words, counts the
// length and writes the padding words. Depends on md5_pkg.
module md5_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_byte_valid,
    input  logic              i_last,
    input  logic              i_wr_free,
    output md5_pkg::t_wr_req  o_wr
);

    md5_pkg::t_front_st r_st, n_st;
    logic [5:0]  r_fill, n_fill;
    logic [60:0] r_len, n_len;
    logic [23:0] r_word, n_word;
    logic [3:0]  r_wi, n_wi;
    logic        r_first, n_first;
    logic        r_lenblk, n_lenblk;
    logic [31:0] pad_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= md5_pkg::F_DATA;
            r_fill   <= '0;
            r_len    <= '0;
            r_wi     <= '0;
            r_first  <= 1'b0;
            r_lenblk <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_fill   <= n_fill;
            r_len    <= n_len;
            r_wi     <= n_wi;
            r_first  <= n_first;
            r_lenblk <= n_lenblk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    // keep the bytes below the fill point, put 0x80 at it, zero above
    always_comb begin
        unique case (r_fill[1:0])
            2'd0: pad_word = 32'h0000_0080;
            2'd1: pad_word = {16'h0000, 8'h80, r_word[7:0]};
            2'd2: pad_word = {8'h00, 8'h80, r_word[15:0]};
            2'd3: pad_word = {8'h80, r_word[23:0]};
            default: pad_word = 32'h0000_0080;
        endcase
    end

    always_comb begin
        n_st     = r_st;
        n_fill   = r_fill;
        n_len    = r_len;
        n_word   = r_word;
        n_wi     = r_wi;
        n_first  = r_first;
        n_lenblk = r_lenblk;
        o_ready  = 1'b0;
        o_wr     = '0;
        unique case (r_st)
            md5_pkg::F_DATA: begin
                o_ready = i_wr_free;
                if (i_valid && i_wr_free) begin
                    if (i_byte_valid) begin
                        n_len = r_len + 61'd1;
                        unique case (r_fill[1:0])
                            2'd0: n_word = {16'h0000, i_data_byte};
                            2'd1: n_word[15:8] = i_data_byte;
                            2'd2: n_word[23:16] = i_data_byte;
                            2'd3: n_word = r_word;
                            default: n_word = r_word;
                        endcase
                        o_wr.we     = (r_fill[1:0] == 2'd3);
                        o_wr.addr   = r_fill[5:2];
                        o_wr.data   = {i_data_byte, r_word};
                        o_wr.commit = (r_fill == 6'd63);
                        n_fill      = r_fill + 6'd1;
                    end
                    if (i_last) begin
                        n_st     = md5_pkg::F_PAD;
                        n_wi     = n_fill[5:2];
                        n_first  = 1'b1;
                        // length fits in this block only below byte 56
                        n_lenblk = (n_fill[5:3] != 3'b111);
                    end
                end
            end
            md5_pkg::F_PAD: begin
                if (i_wr_free) begin
                    o_wr.we   = 1'b1;
                    o_wr.addr = r_wi;
                    if (r_first) begin
                        o_wr.data = pad_word;
                    end else if (r_lenblk && r_wi == 4'd14) begin
                        o_wr.data = {r_len[28:0], 3'b000};
                    end else if (r_lenblk && r_wi == 4'd15) begin
                        o_wr.data = r_len[60:29];
                    end else begin
                        o_wr.data = '0;
                    end
                    n_first = 1'b0;
                    if (r_wi == 4'd15) begin
                        o_wr.commit = 1'b1;
                        o_wr.fin    = r_lenblk;
                        n_wi        = '0;
                        if (r_lenblk) begin
                            n_st   = md5_pkg::F_DATA;
                            n_fill = '0;
                            n_len  = '0;
                        end else begin
                            n_lenblk = 1'b1;
                        end
                    end else begin
                        n_wi = r_wi + 4'd1;
                    end
                end
            end
            default: n_st = md5_pkg::F_DATA;
        endcase
    end

endmodule

[rtl/core/md5_queue.sv]
// Two-slot block queue between front and back: a 32-word memory holding two
// 16-word blocks, with full and final flags per slot. Depends on md5_pkg.
module md5_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  md5_pkg::t_wr_req  i_wr,
    output logic              o_wr_free,
    input  md5_pkg::t_rd_req  i_rd,
    output md5_pkg::t_rd_rsp  o_rd
);

    logic [31:0] r_mem [32];
    logic [31:0] r_rdata;
    logic [1:0]  r_full, n_full;
    logic [1:0]  r_fin;
    logic        r_wsl;
    logic        r_rsl;

    // a commit fills the write slot, a hand-back empties the read slot
    always_comb begin
        n_full = r_full;
        if (i_wr.commit) begin
            n_full[r_wsl] = 1'b1;
        end
        if (i_rd.done) begin
            n_full[r_rsl] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= '0;
            r_wsl  <= 1'b0;
            r_rsl  <= 1'b0;
        end else begin
            r_full <= n_full;
            if (i_wr.commit) begin
                r_wsl <= ~r_wsl;
            end
            if (i_rd.done) begin
                r_rsl <= ~r_rsl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.commit) begin
            r_fin[r_wsl] <= i_wr.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[{r_wsl, i_wr.addr}] <= i_wr.data;
        end
        r_rdata <= r_mem[{r_rsl, i_rd.addr}];
    end

    assign o_wr_free  = !r_full[r_wsl];
    assign o_rd.avail = r_full[r_rsl];
    assign o_rd.fin   = r_fin[r_rsl];
    assign o_rd.data  = r_rdata;

endmodule

[rtl/core/md5_back.sv]
// Back end: 64-round compression, one round per cycle, chaining words and
// digest output. Reads blocks from md5_queue; depends on md5_pkg.
module md5_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  md5_pkg::t_rd_rsp  i_rd,
    output md5_pkg::t_rd_req  o_rd,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [31:0]       o_digest_word,
    output logic [1:0]        o_word_index,
    output logic              o_last_word
);

    md5_pkg::t_back_st r_st, n_st;
    logic [6:0]  r_step, n_step;
    logic [1:0]  r_oidx, n_oidx;
    logic [31:0] r_h [4];
    logic [31:0] n_h [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] r_km, r_akm;
    logic [31:0] n_km, n_akm;
    logic [5:0]  rnd;
    logic [5:0]  km_idx;
    logic        round_en;
    logic [31:0] new_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= md5_pkg::B_IDLE;
            r_step <= '0;
            r_oidx <= '0;
            for (int i = 0; i < 4; i++) begin
                r_h[i] <= md5_pkg::IV[i];
            end
        end else begin
            r_st   <= n_st;
            r_step <= n_step;
            r_oidx <= n_oidx;
            for (int i = 0; i < 4; i++) begin
                r_h[i] <= n_h[i];
            end
        end
    end

    // message word of round j is addressed at step j, then added to K and a
    assign rnd      = 6'(r_step - md5_pkg::STEP_FIRST_ROUND);
    assign km_idx   = 6'(r_step - 7'd1);
    assign round_en = (r_st == md5_pkg::B_RUN) && (r_step >= md5_pkg::STEP_FIRST_ROUND);
    assign n_km     = i_rd.data + md5_pkg::RK[km_idx];
    // a of the next round is the current d, or h0 before the first round
    assign n_akm    = ((r_step == md5_pkg::STEP_FIRST_AKM) ? r_h[0] : r_d) + r_km;
    assign new_b    = r_b + md5_pkg::rol(md5_pkg::round_f(rnd[5:4], r_b, r_c, r_d) + r_akm,
                                         md5_pkg::ROT[{rnd[5:4], rnd[1:0]}]);

    always_ff @(posedge i_clk) begin
        r_km  <= n_km;
        r_akm <= n_akm;
        if (r_st == md5_pkg::B_IDLE) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
        end else if (round_en) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= new_b;
        end
    end

    always_comb begin
        n_st      = r_st;
        n_step    = r_step;
        n_oidx    = r_oidx;
        for (int i = 0; i < 4; i++) begin
            n_h[i] = r_h[i];
        end
        o_rd.addr = md5_pkg::msg_index(r_step[5:0]);
        o_rd.done = 1'b0;
        o_valid   = 1'b0;
        unique case (r_st)
            md5_pkg::B_IDLE: begin
                n_step = '0;
                if (i_rd.avail) begin
                    n_st = md5_pkg::B_RUN;
                end
            end
            md5_pkg::B_RUN: begin
                n_step = r_step + 7'd1;
                if (r_step == md5_pkg::STEP_LAST_ROUND) begin
                    n_st = md5_pkg::B_ADD;
                end
            end
            md5_pkg::B_ADD: begin
                n_h[0]    = r_h[0] + r_a;
                n_h[1]    = r_h[1] + r_b;
                n_h[2]    = r_h[2] + r_c;
                n_h[3]    = r_h[3] + r_d;
                o_rd.done = 1'b1;
                n_oidx    = '0;
                n_st      = i_rd.fin ? md5_pkg::B_OUT : md5_pkg::B_IDLE;
            end
            md5_pkg::B_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    if (r_oidx == 2'd3) begin
                        // digest delivered: restart the chain
                        for (int i = 0; i < 4; i++) begin
                            n_h[i] = md5_pkg::IV[i];
                        end
                        n_st = md5_pkg::B_IDLE;
                    end else begin
                        n_oidx = r_oidx + 2'd1;
                    end
                end
            end
            default: n_st = md5_pkg::B_IDLE;
        endcase
    end

    assign o_digest_word = r_h[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 2'd3);

endmodule

[rtl/core/md5_message_digest.sv]
// MD5 digest of a byte stream. Top level: front end, two-block queue and
// compression back end. Depends on md5_pkg, md5_front, md5_queue, md5_back.
//
// Input channel (i_valid/o_ready): one beat carries one message byte
// (i_data_byte, qualified by i_byte_valid) and i_last, which closes the
// message. A last beat with i_byte_valid low ends a message without a byte,
// so an empty message is a single such beat.
// Output channel (o_valid/i_ready): four beats per message, h0..h3 in order,
// o_word_index 0..3, o_last_word on the fourth. Digest bytes are each word
// taken little-endian.
// Throughput: the front takes one byte per cycle while the queue has a free
// slot and it is not writing pad words. Per 64-byte block the back picks up
// the slot, runs one MD5 round per cycle behind a fetch lead (read data,
// K+M, a+K+M), then adds the chain and hands the slot back; meanwhile the
// front can fill the other slot. After the last beat the front writes up to
// 18 pad words, one per cycle while the queue has a free block slot.
// A stalled receiver holds the back end in its output state; the front keeps
// taking bytes until both block slots are full. Reset (synchronous, active
// low) empties the queue and loads the standard initial chaining values.
module md5_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_last_word
);

    md5_pkg::t_wr_req wr;
    md5_pkg::t_rd_req rd_req;
    md5_pkg::t_rd_rsp rd_rsp;
    logic             wr_free;

    md5_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_byte_valid (i_byte_valid),
        .i_last       (i_last),
        .i_wr_free    (wr_free),
        .o_wr         (wr)
    );

    md5_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .o_wr_free (wr_free),
        .i_rd      (rd_req),
        .o_rd      (rd_rsp)
    );

    md5_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd          (rd_rsp),
        .o_rd          (rd_req),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule
